// File: rtl/gradient_magnitude_edge_assert.svh
// assertion macros for the gradient magnitude block
`ifndef GRADIENT_MAGNITUDE_EDGE_ASSERT_SVH
`define GRADIENT_MAGNITUDE_EDGE_ASSERT_SVH
`ifndef SYNTHESIS
`define GME_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define GME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GME_ASSERT(lbl, prop, msg)
`define GME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/gme_pkg.sv
// shared types and constants of the gradient magnitude block
package gme_pkg;
	localparam int PIX_W = 8;
	localparam int SQ_W = 21;
	localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65280;

	localparam logic [1:0] MODE_DIFF = 2'd0;
	localparam logic [1:0] MODE_ROBERTS = 2'd1;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_WIDTH = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_PICK,
		S_GRAD,
		S_SQ,
		S_ROOT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic done;
		logic [7:0] mag;
	} sqrt_res_t;
endpackage

// File: rtl/gme_sqrt.sv
// bit-serial rounded square root, saturated at 255
module gme_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [gme_pkg::SQ_W-1:0] n,
	output gme_pkg::sqrt_res_t res
);
	import gme_pkg::*;

	logic [SQ_W-1:0] n_q;
	logic [7:0] root_q;
	logic [2:0] step_q;
	logic [7:0] mag_q;
	logic busy_q, rnd_q, done_q;
	logic [7:0] trial;
	logic [15:0] tsq;
	logic [16:0] rr;

	always_comb begin
		trial = root_q | (8'd1 << step_q);
		tsq = 16'(trial) * 16'(trial);
		rr = 17'(root_q) * 17'(root_q) + 17'(root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
					rnd_q <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			root_q <= 8'd0;
			step_q <= 3'd7;
		end else if (busy_q) begin
			if (SQ_W'(tsq) <= n_q) root_q <= trial;
			step_q <= step_q - 3'd1;
		end else if (rnd_q) begin
			// round up when n lies above (root + 0.5)^2
			if (n_q > SAT_LIMIT) mag_q <= 8'hFF;
			else if (n_q > SQ_W'(rr)) mag_q <= root_q + 8'd1;
			else mag_q <= root_q;
		end
	end

	assign res.done = done_q;
	assign res.mag = mag_q;
endmodule

// File: rtl/gradient_magnitude_edge.sv
// top level of the streaming gradient magnitude block
// Gray pixels come in raster order, one word per handshake, and leave as
// gradient magnitudes (simple difference, Roberts cross or 3x3 Sobel, picked
// by operator_mode) with reflect-101 borders, rounded and saturated to 255.
// The output lags one row and one column; row ends and the last row release
// extra words, so one pixel gives zero to four results. Each pixel passes
// a line buffer read and write-back (all it does when it gives no result),
// then every result goes through gradient, squares, and an 8-step shared
// square root unit that settles one bit of the root per cycle. One pixel is
// in work at a time. Writing image_width or image_height restarts the image
// at row 0, column 0; operator_mode applies at once.
`include "gradient_magnitude_edge_assert.svh"
module gradient_magnitude_edge #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] pixel,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] magnitude,
	output logic last_of_run,
	output logic end_of_image,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import gme_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

	// configuration registers
	logic [1:0] mode_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [EW-1:0] eff_w;
	logic [15:0] eff_h;

	// position in the image
	logic [CW-1:0] col_q;
	logic [15:0] row_q;
	logic [CW-1:0] c_cur;
	logic [15:0] r_cur;
	logic last_row, row_end;

	// line buffers, one entry per column
	logic [PIX_W-1:0] line2_mem [MAX_WIDTH];
	logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd2_q, rd1_q;

	// per-pixel work registers
	logic [CW-1:0] c_q;
	logic [PIX_W-1:0] pix_q;
	logic [3:0] en_q;
	logic r1_q, c1_q, last_row_q, row_end_q;
	logic [1:0] sel_q;
	logic last_q;
	logic [PIX_W-1:0] win_q [3][3];

	// gradient datapath
	logic signed [11:0] gx, gy, gx_q, gy_q;
	logic [23:0] sqx, sqy;
	logic [SQ_W-1:0] nsum;
	logic [1:0] rm [3];
	logic [1:0] cm [3];
	logic signed [11:0] nb [3][3];
	logic [1:0] pick_sel;
	logic [3:0] en_rest;
	logic [7:0] mag_q;

	state_t state_q, state_d;
	logic sq_start;
	sqrt_res_t sq_res;
	logic in_acc, cfg_acc;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;

	// clamp the geometry registers to the supported range
	always_comb begin
		if (EW'(width_q) < EW'(2)) eff_w = EW'(2);
		else if (EW'(width_q) > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
		else eff_w = EW'(width_q);
		eff_h = (height_q < 16'd2) ? 16'd2 : height_q;
		c_cur = (EW'(col_q) >= eff_w) ? '0 : col_q;
		r_cur = (row_q >= eff_h) ? 16'd0 : row_q;
		last_row = (r_cur == eff_h - 16'd1);
		row_end = (EW'(c_cur) == eff_w - EW'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_READ;
			S_READ: state_d = S_PICK;
			S_PICK: state_d = (en_q == 4'd0) ? S_IDLE : S_GRAD;
			S_GRAD: state_d = S_SQ;
			S_SQ: state_d = S_ROOT;
			S_ROOT: if (sq_res.done) state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_PICK;
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		sq_start = (state_q == S_SQ);
	end

	assign magnitude = mag_q;
	assign last_of_run = last_q;
	assign end_of_image = last_q && last_row_q && row_end_q;

	// next result to produce: lowest pending one
	always_comb begin
		pick_sel = 2'd3;
		if (en_q[0]) pick_sel = 2'd0;
		else if (en_q[1]) pick_sel = 2'd1;
		else if (en_q[2]) pick_sel = 2'd2;
		en_rest = en_q & ~(4'd1 << pick_sel);
	end

	// window rows and columns with reflect-101 at the borders
	always_comb begin
		if (sel_q[0]) begin
			rm[0] = 2'd1;
			rm[1] = 2'd2;
			rm[2] = 2'd1;
		end else begin
			rm[0] = r1_q ? 2'd2 : 2'd0;
			rm[1] = 2'd1;
			rm[2] = 2'd2;
		end
		if (sel_q[1]) begin
			cm[0] = 2'd1;
			cm[1] = 2'd2;
			cm[2] = 2'd1;
		end else begin
			cm[0] = c1_q ? 2'd2 : 2'd0;
			cm[1] = 2'd1;
			cm[2] = 2'd2;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nb[i][j] = signed'({4'd0, win_q[rm[i]][cm[j]]});
			end
		end
	end

	always_comb begin
		case (mode_q)
			MODE_DIFF: begin
				gx = nb[1][1] - nb[1][0];
				gy = nb[1][1] - nb[0][1];
			end
			MODE_ROBERTS: begin
				gx = nb[1][1] - nb[0][0];
				gy = nb[1][0] - nb[0][1];
			end
			default: begin
				gx = (nb[0][2] + (nb[1][2] <<< 1) + nb[2][2])
					- (nb[0][0] + (nb[1][0] <<< 1) + nb[2][0]);
				gy = (nb[2][0] + (nb[2][1] <<< 1) + nb[2][2])
					- (nb[0][0] + (nb[0][1] <<< 1) + nb[0][2]);
			end
		endcase
	end

	// squares of the registered gradients feed the root unit, which registers their sum
	always_comb begin
		sqx = unsigned'(24'(gx_q) * 24'(gx_q));
		sqy = unsigned'(24'(gy_q) * 24'(gy_q));
		nsum = SQ_W'(sqx + sqy);
	end

	gme_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.n(nsum),
		.res(sq_res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 2'd2;
			width_q <= 11'd256;
			height_q <= 16'd256;
			col_q <= '0;
			row_q <= 16'd0;
			en_q <= 4'd0;
			last_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[1:0];
					CFG_WIDTH: begin
						width_q <= cfg_data[10:0];
						col_q <= '0;
						row_q <= 16'd0;
					end
					CFG_HEIGHT: begin
						height_q <= cfg_data;
						col_q <= '0;
						row_q <= 16'd0;
					end
					default: ;
				endcase
			end else if (in_acc) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : r_cur + 16'd1;
				end else begin
					col_q <= c_cur + CW'(1);
					row_q <= r_cur;
				end
			end
			if (in_acc) begin
				en_q[0] <= (r_cur != 16'd0) && (c_cur != '0);
				en_q[1] <= (r_cur != 16'd0) && (c_cur != '0) && last_row;
				en_q[2] <= (r_cur != 16'd0) && row_end;
				en_q[3] <= (r_cur != 16'd0) && row_end && last_row;
			end
			if (state_q == S_READ) begin
				// shift the window one column and bring in the new one
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= rd2_q;
				win_q[1][2] <= rd1_q;
				win_q[2][2] <= pix_q;
			end
			if (state_q == S_PICK && en_q != 4'd0) begin
				en_q <= en_rest;
				last_q <= (en_rest == 4'd0);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			c_q <= c_cur;
			pix_q <= pixel;
			r1_q <= (r_cur == 16'd1);
			c1_q <= (c_cur == CW'(1));
			last_row_q <= last_row;
			row_end_q <= row_end;
		end
		if (state_q == S_PICK) sel_q <= pick_sel;
		if (state_q == S_GRAD) begin
			gx_q <= gx;
			gy_q <= gy;
		end
		if (state_q == S_ROOT && sq_res.done) mag_q <= sq_res.mag;
	end

	// line buffers: read on accept, written back in the following cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd2_q <= line2_mem[c_cur];
			rd1_q <= line1_mem[c_cur];
		end
		if (state_q == S_READ) begin
			line2_mem[c_q] <= rd1_q;
			line1_mem[c_q] <= pix_q;
		end
	end

	`GME_ASSERT(a_col_in_range, EW'(col_q) < eff_w, "column counter beyond image width")
	`GME_ASSERT(a_row_in_range, row_q < eff_h, "row counter beyond image height")
	`GME_ASSERT(a_eoi_last, !(out_valid && end_of_image) || last_of_run, "end of image not last")
	`GME_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready && !out_valid, "pixel overlap")
endmodule
